/* rtl/core/side_offset_of_neighbor_vector_unit_assert.svh */
// Assertion macros shared by the sideways offset unit.
`ifndef SIDE_OFFSET_OF_NEIGHBOR_VECTOR_UNIT_ASSERT_SVH
`define SIDE_OFFSET_OF_NEIGHBOR_VECTOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SONV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sonv assertion failed");
`define SONV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("sonv assertion failed");
`else
`define SONV_ASSERT(lbl, prop)
`define SONV_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* rtl/core/sonv_pkg.sv */
package sonv_pkg;

    localparam int COORD_WIDTH = 8;
    localparam int FRAC_BITS   = 16;
    localparam int IN_WIDTH    = 8;
    localparam int GAIN_WIDTH  = 16;
    localparam int OUT_WIDTH   = 16;
    localparam int CFG_IDX_W   = 8;

    localparam int SUM_W     = 2 * COORD_WIDTH;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int T_W       = Q_W + SUM_W;
    localparam int REM_W     = 2 * COORD_WIDTH + 2 * FRAC_BITS + 2;
    localparam int VAL_W     = COORD_WIDTH + FRAC_BITS;
    localparam int PROD_W    = VAL_W + GAIN_WIDTH + 1;
    localparam int BIT_IDX_W = $clog2(FRAC_BITS + 1);
    localparam int STEPS     = FRAC_BITS + 1;

    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(256);
    localparam logic [OUT_WIDTH-1:0]  OUT_MAX    = {1'b0, {(OUT_WIDTH-1){1'b1}}};
    localparam logic [OUT_WIDTH-1:0]  OUT_MIN    = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_GAIN  = 8'd0,
        CFG_SIDE_SELECT = 8'd1
    } cfg_index_t;

    typedef enum logic {
        SIDE_LEFT  = 1'b0,
        SIDE_RIGHT = 1'b1
    } side_t;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] offset_x;
        logic signed [IN_WIDTH-1:0] offset_y;
        logic signed [IN_WIDTH-1:0] offset_z;
        logic                       last_entry;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] side_x;
        logic signed [OUT_WIDTH-1:0] side_y;
        logic                        not_planar;
        logic                        saturated;
        logic                        last_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [SUM_W-1:0]              s;
        logic                          force_zero;
        logic                          not_planar;
        logic                          last;
    } ctx_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [T_W-1:0]   t;
        logic [Q_W-1:0]   q;
    } root_lane_t;

    typedef struct packed {
        ctx_t       ctx;
        root_lane_t lx;
        root_lane_t ly;
    } root_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic                    not_planar;
        logic                    last;
    } mix_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
        logic                     not_planar;
        logic                     last;
    } prod_t;

endpackage

/* rtl/core/sonv_prep.sv */
module sonv_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              up_valid,
    output logic              up_ready,
    input  sonv_pkg::in_item_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output sonv_pkg::root_t   dn_data
);

    logic                                     valid_reg;
    sonv_pkg::root_t                          data_reg;
    sonv_pkg::root_t                          data_next;
    logic signed [sonv_pkg::COORD_WIDTH-1:0]  x;
    logic signed [sonv_pkg::COORD_WIDTH-1:0]  y;
    logic signed [sonv_pkg::COORD_WIDTH-1:0]  z;
    logic [sonv_pkg::COORD_WIDTH-1:0]         mx;
    logic [sonv_pkg::COORD_WIDTH-1:0]         my;
    logic [sonv_pkg::SUM_W-1:0]               mx2;
    logic [sonv_pkg::SUM_W-1:0]               my2;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        x   = up_data.offset_x[sonv_pkg::COORD_WIDTH-1:0];
        y   = up_data.offset_y[sonv_pkg::COORD_WIDTH-1:0];
        z   = up_data.offset_z[sonv_pkg::COORD_WIDTH-1:0];
        mx  = x[sonv_pkg::COORD_WIDTH-1] ? -x : x;
        my  = y[sonv_pkg::COORD_WIDTH-1] ? -y : y;
        mx2 = sonv_pkg::SUM_W'(mx) * sonv_pkg::SUM_W'(mx);
        my2 = sonv_pkg::SUM_W'(my) * sonv_pkg::SUM_W'(my);

        data_next.ctx.x          = x;
        data_next.ctx.y          = y;
        data_next.ctx.s          = mx2 + my2;
        data_next.ctx.not_planar = (z != '0);
        data_next.ctx.force_zero = (z != '0) || (x == '0 && y == '0);
        data_next.ctx.last       = up_data.last_entry;

        // Remainder starts as a^2 scaled by 2^(2*FRAC_BITS).
        data_next.lx.rem = sonv_pkg::REM_W'(mx2) << (2 * sonv_pkg::FRAC_BITS);
        data_next.ly.rem = sonv_pkg::REM_W'(my2) << (2 * sonv_pkg::FRAC_BITS);
        data_next.lx.t   = '0;
        data_next.ly.t   = '0;
        data_next.lx.q   = '0;
        data_next.ly.q   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/sonv_root_step.sv */
module sonv_root_step (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [sonv_pkg::BIT_IDX_W-1:0]    bit_idx,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  sonv_pkg::root_t                   up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output sonv_pkg::root_t                   dn_data
);

    logic            valid_reg;
    sonv_pkg::root_t data_reg;
    sonv_pkg::root_t data_next;
    logic [sonv_pkg::REM_W-1:0] s_term;

    // One quotient bit per stage: with t = q*s kept alongside, setting bit b
    // costs (t << (b+1)) + (s << 2b) from the remainder a^2*2^2F - q^2*s.
    function automatic sonv_pkg::root_lane_t lane_step(
        input sonv_pkg::root_lane_t      lane,
        input logic [sonv_pkg::SUM_W-1:0] s,
        input logic [sonv_pkg::REM_W-1:0] sq_term,
        input logic [sonv_pkg::BIT_IDX_W-1:0] b
    );
        sonv_pkg::root_lane_t       res;
        logic [sonv_pkg::REM_W-1:0] trial;
        trial = ((sonv_pkg::REM_W'(lane.t) << b) << 1) + sq_term;
        res   = lane;
        if (lane.rem >= trial) begin
            res.rem = lane.rem - trial;
            res.t   = lane.t + (sonv_pkg::T_W'(s) << b);
            res.q   = lane.q | (sonv_pkg::Q_W'(1) << b);
        end
        return res;
    endfunction

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        s_term        = sonv_pkg::REM_W'(up_data.ctx.s) << {bit_idx, 1'b0};
        data_next     = up_data;
        data_next.lx  = lane_step(up_data.lx, up_data.ctx.s, s_term, bit_idx);
        data_next.ly  = lane_step(up_data.ly, up_data.ctx.s, s_term, bit_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/sonv_mix.sv */
module sonv_mix (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            side_select,
    input  logic            up_valid,
    output logic            up_ready,
    input  sonv_pkg::root_t up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output sonv_pkg::mix_t  dn_data
);

    logic                              valid_reg;
    sonv_pkg::mix_t                    data_reg;
    sonv_pkg::mix_t                    data_next;
    logic signed [sonv_pkg::VAL_W-1:0] hx;
    logic signed [sonv_pkg::VAL_W-1:0] hy;
    logic signed [sonv_pkg::VAL_W-1:0] ux;
    logic signed [sonv_pkg::VAL_W-1:0] uy;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        hx = sonv_pkg::VAL_W'(up_data.ctx.x) <<< (sonv_pkg::FRAC_BITS - 1);
        hy = sonv_pkg::VAL_W'(up_data.ctx.y) <<< (sonv_pkg::FRAC_BITS - 1);
        ux = up_data.ctx.x[sonv_pkg::COORD_WIDTH-1] ? -sonv_pkg::VAL_W'(up_data.lx.q)
                                                    :  sonv_pkg::VAL_W'(up_data.lx.q);
        uy = up_data.ctx.y[sonv_pkg::COORD_WIDTH-1] ? -sonv_pkg::VAL_W'(up_data.ly.q)
                                                    :  sonv_pkg::VAL_W'(up_data.ly.q);
        if (side_select == sonv_pkg::SIDE_LEFT) begin
            data_next.vx = hx + uy;
            data_next.vy = hy - ux;
        end else begin
            data_next.vx = hx - uy;
            data_next.vy = hy + ux;
        end
        // Zero vectors and non-planar items leave with a zero offset.
        if (up_data.ctx.force_zero) begin
            data_next.vx = '0;
            data_next.vy = '0;
        end
        data_next.not_planar = up_data.ctx.not_planar;
        data_next.last       = up_data.ctx.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/sonv_gain.sv */
module sonv_gain (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [sonv_pkg::GAIN_WIDTH-1:0]   shift_gain,
    input  logic                              up_valid,
    output logic                              up_ready,
    input  sonv_pkg::mix_t                    up_data,
    output logic                              dn_valid,
    input  logic                              dn_ready,
    output sonv_pkg::prod_t                   dn_data
);

    logic                                    valid_reg;
    sonv_pkg::prod_t                         data_reg;
    sonv_pkg::prod_t                         data_next;
    logic signed [sonv_pkg::GAIN_WIDTH:0]    gain_s;

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        gain_s               = $signed({1'b0, shift_gain});
        data_next.px         = sonv_pkg::PROD_W'(up_data.vx) * sonv_pkg::PROD_W'(gain_s);
        data_next.py         = sonv_pkg::PROD_W'(up_data.vy) * sonv_pkg::PROD_W'(gain_s);
        data_next.not_planar = up_data.not_planar;
        data_next.last       = up_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/sonv_round.sv */
module sonv_round (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                up_valid,
    output logic                up_ready,
    input  sonv_pkg::prod_t     up_data,
    output logic                dn_valid,
    input  logic                dn_ready,
    output sonv_pkg::out_item_t dn_data
);

    logic                  valid_reg;
    sonv_pkg::out_item_t   data_reg;
    sonv_pkg::out_item_t   data_next;
    logic                  sat_x;
    logic                  sat_y;

    // Round half away from zero on the magnitude, then clip to 16 bits.
    function automatic logic [sonv_pkg::OUT_WIDTH-1:0] round_sat(
        input  logic signed [sonv_pkg::PROD_W-1:0] p,
        output logic                               sat
    );
        logic                        neg;
        logic [sonv_pkg::PROD_W-1:0] mag;
        logic [sonv_pkg::PROD_W-1:0] r;
        logic [sonv_pkg::OUT_WIDTH-1:0] res;
        neg = p[sonv_pkg::PROD_W-1];
        mag = neg ? -p : p;
        r   = (mag + (sonv_pkg::PROD_W'(1) << (sonv_pkg::FRAC_BITS + 7)))
              >> (sonv_pkg::FRAC_BITS + 8);
        sat = 1'b0;
        if (!neg) begin
            if (r > sonv_pkg::PROD_W'(sonv_pkg::OUT_MAX)) begin
                res = sonv_pkg::OUT_MAX;
                sat = 1'b1;
            end else begin
                res = r[sonv_pkg::OUT_WIDTH-1:0];
            end
        end else begin
            if (r > sonv_pkg::PROD_W'(sonv_pkg::OUT_MIN)) begin
                res = sonv_pkg::OUT_MIN;
                sat = 1'b1;
            end else begin
                res = -r[sonv_pkg::OUT_WIDTH-1:0];
            end
        end
        return res;
    endfunction

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        data_next.side_x     = round_sat(up_data.px, sat_x);
        data_next.side_y     = round_sat(up_data.py, sat_y);
        data_next.saturated  = sat_x || sat_y;
        data_next.not_planar = up_data.not_planar;
        data_next.last_out   = up_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

/* rtl/core/side_offset_of_neighbor_vector_unit.sv */
// Registered stages from an accepted input beat to its result beat: input stage,
// 17 square-root/divide bit stages, sum, gain multiply, round. Throughput: one beat
// per cycle while m_ready is high; every stage holds its beat until the next takes it.
// Reset (aresetn low, synchronous) empties the pipeline and sets shift_gain to 1.0
// and side_select to left. Configuration writes complete in the cycle they are presented.
`include "side_offset_of_neighbor_vector_unit_assert.svh"

module side_offset_of_neighbor_vector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sonv_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sonv_pkg::out_item_t                 m_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sonv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sonv_pkg::GAIN_WIDTH-1:0]     cfg_data
);

    logic [sonv_pkg::GAIN_WIDTH-1:0] gain_reg;
    logic                            side_reg;

    logic            rt_valid [sonv_pkg::STEPS+1];
    logic            rt_ready [sonv_pkg::STEPS+1];
    sonv_pkg::root_t rt_data  [sonv_pkg::STEPS+1];

    logic            mx_valid;
    logic            mx_ready;
    sonv_pkg::mix_t  mx_data;
    logic            pr_valid;
    logic            pr_ready;
    sonv_pkg::prod_t pr_data;

    logic            out_zero;
    logic            out_at_rail;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= sonv_pkg::GAIN_RESET;
            side_reg <= sonv_pkg::SIDE_LEFT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sonv_pkg::CFG_SHIFT_GAIN:  gain_reg <= cfg_data;
                sonv_pkg::CFG_SIDE_SELECT: side_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sonv_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .up_data  (s_item),
        .dn_valid (rt_valid[0]),
        .dn_ready (rt_ready[0]),
        .dn_data  (rt_data[0])
    );

    for (genvar k = 0; k < sonv_pkg::STEPS; k++) begin : g_step
        sonv_root_step u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .bit_idx  (sonv_pkg::BIT_IDX_W'(sonv_pkg::FRAC_BITS - k)),
            .up_valid (rt_valid[k]),
            .up_ready (rt_ready[k]),
            .up_data  (rt_data[k]),
            .dn_valid (rt_valid[k+1]),
            .dn_ready (rt_ready[k+1]),
            .dn_data  (rt_data[k+1])
        );
    end

    sonv_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .side_select (side_reg),
        .up_valid    (rt_valid[sonv_pkg::STEPS]),
        .up_ready    (rt_ready[sonv_pkg::STEPS]),
        .up_data     (rt_data[sonv_pkg::STEPS]),
        .dn_valid    (mx_valid),
        .dn_ready    (mx_ready),
        .dn_data     (mx_data)
    );

    sonv_gain u_gain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_gain (gain_reg),
        .up_valid   (mx_valid),
        .up_ready   (mx_ready),
        .up_data    (mx_data),
        .dn_valid   (pr_valid),
        .dn_ready   (pr_ready),
        .dn_data    (pr_data)
    );

    sonv_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (pr_valid),
        .up_ready (pr_ready),
        .up_data  (pr_data),
        .dn_valid (m_valid),
        .dn_ready (m_ready),
        .dn_data  (m_item)
    );

    assign out_zero    = (m_item.side_x == '0) && (m_item.side_y == '0) && !m_item.saturated;
    assign out_at_rail = (m_item.side_x == sonv_pkg::OUT_MAX)
                      || (m_item.side_x == sonv_pkg::OUT_MIN)
                      || (m_item.side_y == sonv_pkg::OUT_MAX)
                      || (m_item.side_y == sonv_pkg::OUT_MIN);

    // An empty output stage means every stage upstream can move.
    `SONV_ASSERT(a_ready_when_out_empty, !m_valid |-> s_ready)
    `SONV_ASSERT(a_nonplanar_zero, m_valid && m_item.not_planar |-> out_zero)
    `SONV_ASSERT(a_sat_at_rail, m_valid && m_item.saturated |-> out_at_rail)
    `SONV_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid)

endmodule

/* bench/side_offset_of_neighbor_vector_unit_tb.sv */
module side_offset_of_neighbor_vector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sonv_pkg::*;

    localparam int LATENCY = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd5;

    // Expected side offsets, computed as each input beat is accepted.
    class side_offset_scoreboard;
        out_item_t pending[$];
        logic [GAIN_WIDTH-1:0] gain;
        side_t side;
        int mismatches;
        int checked;

        function void reset_regs();
            gain = GAIN_RESET;
            side = SIDE_LEFT;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_WIDTH-1:0] data);
            if (idx == CFG_SHIFT_GAIN)
                gain = data;
            else if (idx == CFG_SIDE_SELECT)
                side = side_t'(data[0]);
        endfunction

        // floor(a * 2^FRAC_BITS / sqrt(s)), found one quotient bit at a time.
        function longint unsigned unit_magnitude(longint unsigned a, longint unsigned s);
            longint unsigned target;
            longint unsigned q;
            longint unsigned c;
            target = (a * a) << (2 * FRAC_BITS);
            q = 0;
            for (int b = FRAC_BITS; b >= 0; b--) begin
                c = q | (64'd1 << b);
                if (c * c * s <= target)
                    q = c;
            end
            return q;
        endfunction

        function longint signed_unit(longint a, longint unsigned s);
            longint q;
            q = longint'(unit_magnitude(a < 0 ? -a : a, s));
            return a < 0 ? -q : q;
        endfunction

        function logic [OUT_WIDTH-1:0] scale_round(longint v, ref logic sat);
            longint p;
            longint unsigned m;
            longint unsigned r;
            p = v * longint'(gain);
            m = p < 0 ? -p : p;
            r = (m + (64'd1 << (FRAC_BITS + 7))) >> (FRAC_BITS + 8);
            if (p >= 0) begin
                if (r > 32767) begin
                    r = 32767;
                    sat = 1'b1;
                end
                return r[OUT_WIDTH-1:0];
            end
            if (r > 32768) begin
                r = 32768;
                sat = 1'b1;
            end
            return OUT_WIDTH'(-r);
        endfunction

        function void note_input(in_item_t it);
            out_item_t exp_item;
            longint x, y, ux, uy, vx, vy;
            longint unsigned s;
            logic sat;
            x = it.offset_x;
            y = it.offset_y;
            sat = 1'b0;
            exp_item = '0;
            exp_item.last_out = it.last_entry;
            exp_item.not_planar = (it.offset_z != 0);
            if (!exp_item.not_planar && (x != 0 || y != 0)) begin
                s = x * x + y * y;
                ux = signed_unit(x, s);
                uy = signed_unit(y, s);
                if (side == SIDE_LEFT) begin
                    vx = x * (64'sd1 << (FRAC_BITS - 1)) + uy;
                    vy = y * (64'sd1 << (FRAC_BITS - 1)) - ux;
                end else begin
                    vx = x * (64'sd1 << (FRAC_BITS - 1)) - uy;
                    vy = y * (64'sd1 << (FRAC_BITS - 1)) + ux;
                end
                exp_item.side_x = scale_round(vx, sat);
                exp_item.side_y = scale_round(vy, sat);
                exp_item.saturated = sat;
            end
            pending.push_back(exp_item);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result beat with nothing expected: %p", got);
                return;
            end
            exp_item = pending.pop_front();
            if (got.side_x !== exp_item.side_x || got.side_y !== exp_item.side_y
                    || got.not_planar !== exp_item.not_planar
                    || got.saturated !== exp_item.saturated
                    || got.last_out !== exp_item.last_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result %0d differs: expected %p, got %p",
                             checked, exp_item, got);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAIN_WIDTH-1:0] cfg_data = '0;

    side_offset_scoreboard sb = new();
    int cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    side_offset_of_neighbor_vector_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Inputs change only at rising edges, so the falling edge sees what the next
    // rising edge will act on.
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_item);
    end

    // Receiver alternates between free flow, random stalls and long stalls.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    task automatic send_beat(in_item_t it);
        logic fire;
        s_item <= it;
        s_valid <= 1'b1;
        do begin
            @(negedge aclk);
            fire = s_valid && s_ready;
            @(posedge aclk);
        end while (!fire);
        sb.note_input(it);
        items_sent++;
    endtask

    // Bursts of back-to-back beats separated by random gaps.
    task automatic send_paced(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        send_beat(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_WIDTH-1:0] data);
        logic fire;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do begin
            @(negedge aclk);
            fire = cfg_valid && cfg_ready;
            @(posedge aclk);
        end while (!fire);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic in_item_t make_item(int x, int y, int z, bit last);
        in_item_t it;
        it.offset_x = IN_WIDTH'(x);
        it.offset_y = IN_WIDTH'(y);
        it.offset_z = IN_WIDTH'(z);
        it.last_entry = last;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        it = ($bits(in_item_t))'($urandom());
        // Most beats are planar so the arithmetic path is exercised.
        if ($urandom_range(0, 9) != 0)
            it.offset_z = '0;
        it.last_entry = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 15) == 0) begin
            it.offset_x = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
            it.offset_y = IN_WIDTH'(int'($urandom_range(0, 3)) - 1);
        end
        return it;
    endfunction

    logic [GAIN_WIDTH-1:0] gains[8] = '{16'd256, 16'd65535, 16'd0, 16'd1,
                                        16'd512, 16'd0, 16'd65535, 16'd256};

    initial begin
        sb.reset_regs();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at reset settings: extremes, zero vector, off-plane offsets.
        send_beat(make_item(0, 0, 0, 0));
        send_beat(make_item(127, 127, 0, 0));
        send_beat(make_item(-128, -128, 0, 1));
        send_beat(make_item(127, -128, 0, 0));
        send_beat(make_item(-128, 127, 0, 0));
        send_beat(make_item(1, 0, 0, 0));
        send_beat(make_item(0, -1, 0, 0));
        send_beat(make_item(-1, 1, 0, 0));
        send_beat(make_item(3, 4, 0, 0));
        send_beat(make_item(5, 5, 1, 0));
        send_beat(make_item(0, 0, -128, 1));
        send_beat(make_item(-128, 0, 127, 0));
        drain();
        write_reg(CFG_SHIFT_GAIN, 16'hffff);
        write_reg(CFG_SIDE_SELECT, GAIN_WIDTH'(SIDE_RIGHT));
        write_reg(CFG_UNUSED_INDEX, 16'h1234);
        send_beat(make_item(127, 127, 0, 0));
        send_beat(make_item(-128, -128, 0, 0));
        send_beat(make_item(127, 0, 0, 0));
        send_beat(make_item(0, -128, 0, 1));
        send_beat(make_item(1, 1, 0, 0));
        send_beat(make_item(-128, 127, 64, 0));
        drain();

        for (int phase = 0; phase < 16; phase++) begin
            if (phase < 8)
                write_reg(CFG_SHIFT_GAIN, gains[phase]);
            else
                write_reg(CFG_SHIFT_GAIN, GAIN_WIDTH'($urandom()));
            write_reg(CFG_SIDE_SELECT,
                      GAIN_WIDTH'(phase % 2 == 0 ? SIDE_LEFT : SIDE_RIGHT));
            for (int n = 0; n < 118; n++)
                send_paced(random_item());
            drain();
        end

        $display("Sent %0d offsets and checked %0d results over 18 gain and side settings.",
                 items_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d bad results, %0d missing", sb.mismatches, sb.pending.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
